/* sv/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, state codes and control structs for the forest-fire
// automaton step engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // grid geometry
  localparam int GRID_ROWS    = 256;
  localparam int GRID_COLUMNS = 512;

  // field widths
  localparam int STATE_W   = 2;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 9;
  localparam int DRAW_W    = 16;
  localparam int REM_CNT_W = $clog2(DRAW_W + 1);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_GROWTH_PERIOD = 1'b0;
  localparam logic REG_NEIGHBOURHOOD = 1'b1;
  localparam logic [DRAW_W-1:0] GROWTH_PERIOD_RESET = 16'd100;
  localparam logic              NEIGHBOURHOOD_RESET = 1'b1;

  // cell state codes
  localparam logic [STATE_W-1:0] ST_EMPTY = 2'd0;
  localparam logic [STATE_W-1:0] ST_TREE  = 2'd1;
  localparam logic [STATE_W-1:0] ST_FIRE  = 2'd2;
  localparam logic [STATE_W-1:0] ST_BAD   = 2'd3;

  // last positions of the grid
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLUMNS - 1);

  // commands from controller to datapath
  typedef struct packed {
    logic capture;      // take the accepted request
    logic update;       // shift window, write line buffers
    logic div_start;    // start remainder unit
    logic div_sel_old;  // 0: held draw, 1: draw read this cell
    logic g1_latch;     // keep growth flag of first result
    logic g2_latch;     // keep growth flag of second result
    logic second;       // output mux selects second result
    logic advance;      // step counters, move draw along
  } ffa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic emit_first;
    logic emit_second;
    logic div_done;
  } ffa_status_t;

endpackage : ffa_pkg

`default_nettype wire

/* sv/ffa_in_if.sv */
// ----------------------------------------------------------------------------
// ffa_in_if
// Input channel: one old-grid cell with its random draw.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_in_if
  import ffa_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   cell_state;
  logic [DRAW_W-1:0]    growth_draw;

  modport source (output valid, output cell_state, output growth_draw, input ready);
  modport sink   (input valid, input cell_state, input growth_draw, output ready);
endinterface : ffa_in_if

`default_nettype wire

/* sv/ffa_out_if.sv */
// ----------------------------------------------------------------------------
// ffa_out_if
// Output channel: next state of one cell with its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_out_if
  import ffa_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   next_state;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic                 frame_last;

  modport source (output valid, output next_state, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input next_state, input out_row, input out_col,
                  input frame_last, output ready);
endinterface : ffa_out_if

`default_nettype wire

/* sv/ffa_rem.sv */
// ----------------------------------------------------------------------------
// ffa_rem
// Restoring remainder unit, one dividend bit per cycle; flags a zero
// remainder when done.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_rem
  import ffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DRAW_W-1:0] dividend,
  input  wire logic [DRAW_W-1:0] divisor,
  output logic                   done,
  output logic                   rem_zero
);

  logic [DRAW_W-1:0]    acc;
  logic [DRAW_W-1:0]    dvd;
  logic [DRAW_W-1:0]    dsr;
  logic [REM_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DRAW_W:0]      trial;
  logic [DRAW_W:0]      diff;

  // shift in next dividend bit and try to subtract
  assign trial = {acc, dvd[DRAW_W-1]};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= REM_CNT_W'(DRAW_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == REM_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DRAW_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        acc <= diff[DRAW_W-1:0];
      end else begin
        acc <= trial[DRAW_W-1:0];
      end
    end
  end

  assign rem_zero = (acc == '0);

endmodule : ffa_rem

`default_nettype wire

/* sv/ffa_dp.sv */
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: line buffers, draw delay line, 3x3 window, counters, remainder
// unit and the next-state logic for the two possible results of a cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp
  import ffa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ffa_cmd_t           cmd,
  output ffa_status_t             status,
  input  wire logic [STATE_W-1:0] cell_state,
  input  wire logic [DRAW_W-1:0]  growth_draw,
  input  wire logic [DRAW_W-1:0]  growth_period,
  input  wire logic               neighbourhood_mode,
  output logic [STATE_W-1:0]      next_state,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic                    frame_last
);

  // line buffers and draw delay line
  logic [STATE_W-1:0] older_row_line [GRID_COLUMNS];
  logic [STATE_W-1:0] newer_row_line [GRID_COLUMNS];
  logic [DRAW_W-1:0]  delayed_draws  [GRID_COLUMNS];

  logic [STATE_W-1:0] rd_old;
  logic [STATE_W-1:0] rd_new;
  logic [DRAW_W-1:0]  rd_draw;

  logic [STATE_W-1:0] win [9];
  logic [ROW_W-1:0]   row_cnt;
  logic [COL_W-1:0]   col_cnt;
  logic [STATE_W-1:0] cap_state;
  logic [DRAW_W-1:0]  cap_draw;
  logic [DRAW_W-1:0]  old_draw;
  logic [DRAW_W-1:0]  held_draw;
  logic               grow1;
  logic               grow2;

  logic [DRAW_W-1:0]  divisor;
  logic [DRAW_W-1:0]  dividend;
  logic               rem_done;
  logic               rem_zero;
  logic               top_ok;
  logic               left_ok;
  logic [STATE_W-1:0] ns1;
  logic [STATE_W-1:0] ns2;

  // next state of one cell from its neighbourhood
  function automatic logic [STATE_W-1:0] evolve(
    input logic [STATE_W-1:0] centre,
    input logic [STATE_W-1:0] up_l,
    input logic [STATE_W-1:0] up,
    input logic [STATE_W-1:0] up_r,
    input logic [STATE_W-1:0] lft,
    input logic [STATE_W-1:0] rgt,
    input logic [STATE_W-1:0] dn_l,
    input logic [STATE_W-1:0] dn,
    input logic [STATE_W-1:0] dn_r,
    input logic               up_ok,
    input logic               l_ok,
    input logic               r_ok,
    input logic               moore,
    input logic               grow
  );
    logic burn;
    burn = (up_ok && up == ST_FIRE) || (dn == ST_FIRE) ||
           (l_ok && lft == ST_FIRE) || (r_ok && rgt == ST_FIRE) ||
           (moore && up_ok && l_ok && up_l == ST_FIRE) ||
           (moore && up_ok && r_ok && up_r == ST_FIRE) ||
           (moore && l_ok && dn_l == ST_FIRE) ||
           (moore && r_ok && dn_r == ST_FIRE);
    if (centre == ST_FIRE) begin
      return ST_EMPTY;
    end else if (centre == ST_EMPTY) begin
      return grow ? ST_TREE : ST_EMPTY;
    end else begin
      return burn ? ST_FIRE : ST_TREE;
    end
  endfunction

  // line buffer read, registered, at the current column
  always_ff @(posedge clk) begin
    rd_old  <= older_row_line[col_cnt];
    rd_new  <= newer_row_line[col_cnt];
    rd_draw <= delayed_draws[col_cnt];
    if (cmd.update) begin
      older_row_line[col_cnt] <= rd_new;
      newer_row_line[col_cnt] <= cap_state;
      delayed_draws[col_cnt]  <= cap_draw;
    end
  end

  // capture request; bottom row reads as fire, code three as empty
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_draw <= growth_draw;
      if (row_cnt == ROW_LAST) begin
        cap_state <= ST_FIRE;
      end else if (cell_state == ST_BAD) begin
        cap_state <= ST_EMPTY;
      end else begin
        cap_state <= cell_state;
      end
    end
    if (cmd.update) begin
      old_draw <= rd_draw;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= ST_EMPTY;
      end
    end else if (cmd.update) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= rd_old;
      win[5] <= rd_new;
      win[8] <= cap_state;
    end
  end

  // raster counters and held draw
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      held_draw <= '0;
    end else if (cmd.advance) begin
      held_draw <= old_draw;
      if (col_cnt == COL_LAST) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == ROW_LAST) ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // growth test: draw modulo period, zero period acts as one
  assign divisor  = (growth_period == '0) ? DRAW_W'(1) : growth_period;
  assign dividend = cmd.div_sel_old ? old_draw : held_draw;

  ffa_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (cmd.g1_latch) begin
      grow1 <= rem_zero;
    end
    if (cmd.g2_latch) begin
      grow2 <= rem_zero;
    end
  end

  // in-grid tests for the described cell
  assign top_ok  = (row_cnt != ROW_W'(1));
  assign left_ok = (col_cnt != COL_W'(1));

  // first result: centre in window column one
  assign ns1 = evolve(win[4], win[0], win[1], win[2], win[3], win[5],
                      win[6], win[7], win[8], top_ok, left_ok, 1'b1,
                      neighbourhood_mode, grow1);

  // second result: centre in window column two, right edge of the grid
  assign ns2 = evolve(win[5], win[1], win[2], ST_EMPTY, win[4], ST_EMPTY,
                      win[7], win[8], ST_EMPTY, top_ok, 1'b1, 1'b0,
                      neighbourhood_mode, grow2);

  // result payload
  assign next_state = cmd.second ? ns2 : ns1;
  assign out_row    = row_cnt - 1'b1;
  assign out_col    = cmd.second ? col_cnt : col_cnt - 1'b1;
  assign frame_last = cmd.second && (row_cnt == ROW_LAST);

  // status
  assign status.emit_first  = (row_cnt != '0) && (col_cnt != '0);
  assign status.emit_second = (row_cnt != '0) && (col_cnt == COL_LAST);
  assign status.div_done    = rem_done;

endmodule : ffa_dp

`default_nettype wire

/* sv/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl
// Controller: walks one cell through read, window update, growth tests
// and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl
  import ffa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire ffa_status_t status,
  output ffa_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_UPDATE = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_DIV1   = 4'd4;
  localparam logic [3:0] S_DIV2   = 4'd5;
  localparam logic [3:0] S_EMIT1  = 4'd6;
  localparam logic [3:0] S_EMIT2  = 4'd7;
  localparam logic [3:0] S_ADV    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.emit_first) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV1;
        end else begin
          state_next = S_ADV;
        end
      end
      S_DIV1: begin
        if (status.div_done) begin
          cmd.g1_latch = 1'b1;
          if (status.emit_second) begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_old = 1'b1;
            state_next      = S_DIV2;
          end else begin
            state_next = S_EMIT1;
          end
        end
      end
      S_DIV2: begin
        cmd.div_sel_old = 1'b1;
        if (status.div_done) begin
          cmd.g2_latch = 1'b1;
          state_next   = S_EMIT1;
        end
      end
      S_EMIT1: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.emit_second ? S_EMIT2 : S_ADV;
        end
      end
      S_EMIT2: begin
        out_valid  = 1'b1;
        cmd.second = 1'b1;
        if (out_ready) begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : ffa_ctrl

`default_nettype wire

/* sv/forest_fire_automaton_step.sv */
// ----------------------------------------------------------------------------
// forest_fire_automaton_step
// One generation of a forest-fire automaton over a 256 x 512 grid, streamed.
// ----------------------------------------------------------------------------
// Cells of the old grid enter on cell_in in raster order, each with its
// state and a random draw. Results leave on cell_out one row and one
// column behind: no result for row 0 or column 0, one for each inner
// column, and two at the last column (cell c-1, then cell c). The bottom
// row is forced to fire and never comes out; frame_last marks the final
// result of a generation.
// The block handles one cell at a time and takes no new cell until it is
// through with the last one; each result needs one growth test in the
// bit-serial remainder unit, the line buffer read is registered, and a
// result waits while the receiver holds ready low.
// Results are shown from the controller's emit states and held until
// taken; no new cell is accepted while a result waits.
// Reset clears the counters, the window and the controller; the line
// buffers need no clearing, and growth_period and neighbourhood_mode
// return to 100 and Moore. The user writes registers over the APB port
// only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_fire_automaton_step
  import ffa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  ffa_in_if.sink                     cell_in,
  ffa_out_if.source                  cell_out
);

  logic [DRAW_W-1:0] growth_period;
  logic              neighbourhood_mode;
  ffa_cmd_t          cmd;
  ffa_status_t       status;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_period      <= GROWTH_PERIOD_RESET;
      neighbourhood_mode <= NEIGHBOURHOOD_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_GROWTH_PERIOD: growth_period      <= pwdata[DRAW_W-1:0];
        REG_NEIGHBOURHOOD: neighbourhood_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[2])
      REG_GROWTH_PERIOD: prdata = CFG_DATA_W'(growth_period);
      REG_NEIGHBOURHOOD: prdata = CFG_DATA_W'(neighbourhood_mode);
      default:           prdata = '0;
    endcase
  end

  // controller
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .out_valid (cell_out.valid),
    .out_ready (cell_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  ffa_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cell_state         (cell_in.cell_state),
    .growth_draw        (cell_in.growth_draw),
    .growth_period      (growth_period),
    .neighbourhood_mode (neighbourhood_mode),
    .next_state         (cell_out.next_state),
    .out_row            (cell_out.out_row),
    .out_col            (cell_out.out_col),
    .frame_last         (cell_out.frame_last)
  );

endmodule : forest_fire_automaton_step

`default_nettype wire

/* sv/ffa_checker.sv */
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks for the forest-fire step engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_checker
  import ffa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [STATE_W-1:0] next_state,
  input wire logic [ROW_W-1:0]   out_row,
  input wire logic [COL_W-1:0]   out_col,
  input wire logic               frame_last
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // no request taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  // a result never appears right after a request is taken
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("result or request too soon after a request");

  // end of generation only at the last output cell
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> out_row == ROW_W'(GRID_ROWS - 2) && out_col == COL_LAST)
    else $error("frame_last away from the last output cell");

  // only legal state codes leave the block
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> next_state != ST_BAD)
    else $error("illegal next_state code");

endmodule : ffa_checker

bind forest_fire_automaton_step ffa_checker u_ffa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cell_in.valid),
  .in_ready   (cell_in.ready),
  .out_valid  (cell_out.valid),
  .out_ready  (cell_out.ready),
  .next_state (cell_out.next_state),
  .out_row    (cell_out.out_row),
  .out_col    (cell_out.out_col),
  .frame_last (cell_out.frame_last)
);

`default_nettype wire

/* bench/forest_fire_automaton_step_tb.sv */
// ----------------------------------------------------------------------------
// forest_fire_automaton_step_tb
// Self-checking bench for the streamed forest-fire generation step.
// ----------------------------------------------------------------------------
// Old-grid cells are streamed in raster order while an in-bench model of the
// line buffers and 3x3 window predicts every next-state result, which is
// compared field by field as results are taken. The run covers the top and
// left grid edges, the double result at the right edge, both neighbourhoods,
// growth-period extremes, random gaps on both channels and one long output
// hold that backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_fire_automaton_step_tb;
  import ffa_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_MAX       = 18;
  localparam int RANDOM_ITEMS   = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 10;

  localparam logic MODE_VON_NEUMANN = 1'b0;
  localparam logic MODE_MOORE       = 1'b1;

  typedef enum int {MIX_UNIFORM, MIX_FOREST, MIX_GROWTH} cell_mix_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } cell_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ffa_in_if  cell_in_bus ();
  ffa_out_if cell_out_bus ();

  forest_fire_automaton_step u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cell_in  (cell_in_bus),
    .cell_out (cell_out_bus)
  );

  // grid model state
  logic [STATE_W-1:0] older_line [GRID_COLUMNS];
  logic [STATE_W-1:0] newer_line [GRID_COLUMNS];
  logic [DRAW_W-1:0]  draw_line  [GRID_COLUMNS];
  logic [STATE_W-1:0] win [9];
  logic [DRAW_W-1:0]  held_grow_draw;
  int                 cur_row;
  int                 cur_col;
  logic [DRAW_W-1:0]  period_reg;
  logic               moore_reg;

  cell_result_t pending_results [$];
  int           fail_count;
  bit           sender_idle;
  bit           receiver_idle;
  int           receiver_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch: %s expected %0d got %0d", what, want, got);
  endfunction

  function automatic void reset_prediction();
    for (int i = 0; i < GRID_COLUMNS; i++) begin
      older_line[i] = ST_EMPTY;
      newer_line[i] = ST_EMPTY;
      draw_line[i]  = '0;
    end
    for (int i = 0; i < 9; i++)
      win[i] = ST_EMPTY;
    held_grow_draw = '0;
    cur_row        = 0;
    cur_col        = 0;
    period_reg     = GROWTH_PERIOD_RESET;
    moore_reg      = NEIGHBOURHOOD_RESET;
  endfunction

  // next state of the centre-row cell at window column wcol
  function automatic logic [STATE_W-1:0] cell_next_state(int wcol, int row, int col,
                                                         logic [DRAW_W-1:0] draw);
    logic [STATE_W-1:0] centre;
    int                 period;
    int                 wc;
    centre = win[3 + wcol];
    if (centre == ST_FIRE)
      return ST_EMPTY;
    if (centre == ST_EMPTY) begin
      period = (period_reg == 0) ? 1 : int'(period_reg);
      return (int'(draw) % period == 0) ? ST_TREE : ST_EMPTY;
    end
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        wc = wcol + dc;
        if (dr == 0 && dc == 0)
          continue;
        if (moore_reg == MODE_VON_NEUMANN && dr != 0 && dc != 0)
          continue;
        if (row + dr < 0 || row + dr >= GRID_ROWS || col + dc < 0 || col + dc >= GRID_COLUMNS)
          continue;
        if (wc < 0 || wc > 2)
          continue;
        if (win[(1 + dr) * 3 + wc] == ST_FIRE)
          return ST_FIRE;
      end
    end
    return ST_TREE;
  endfunction

  // take one accepted cell into the model and queue the results it causes
  function automatic void absorb_cell(logic [STATE_W-1:0] st_in, logic [DRAW_W-1:0] draw);
    logic [STATE_W-1:0] st;
    logic [DRAW_W-1:0]  old_draw;
    cell_result_t       res;
    st = (st_in == ST_BAD) ? ST_EMPTY : st_in;
    if (cur_row == GRID_ROWS - 1)
      st = ST_FIRE;
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = older_line[cur_col];
    win[5] = newer_line[cur_col];
    win[8] = st;
    older_line[cur_col] = newer_line[cur_col];
    newer_line[cur_col] = st;
    old_draw = draw_line[cur_col];
    draw_line[cur_col] = draw;
    if (cur_row >= 1 && cur_col >= 1) begin
      res.state = cell_next_state(1, cur_row - 1, cur_col - 1, held_grow_draw);
      res.row   = ROW_W'(cur_row - 1);
      res.col   = COL_W'(cur_col - 1);
      res.last  = 1'b0;
      pending_results.insert(pending_results.size(), res);
    end
    if (cur_row >= 1 && cur_col == GRID_COLUMNS - 1) begin
      res.state = cell_next_state(2, cur_row - 1, cur_col, old_draw);
      res.row   = ROW_W'(cur_row - 1);
      res.col   = COL_W'(cur_col);
      res.last  = (cur_row == GRID_ROWS - 1);
      pending_results.insert(pending_results.size(), res);
    end
    held_grow_draw = old_draw;
    if (cur_col + 1 >= GRID_COLUMNS) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= GRID_ROWS) ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endfunction

  function automatic logic [STATE_W-1:0] pick_state(cell_mix_t mix);
    int n;
    n = $urandom_range(0, 99);
    case (mix)
      MIX_FOREST: begin
        if (n < 4) return ST_FIRE;
        if (n < 14) return ST_EMPTY;
        if (n < 16) return ST_BAD;
        return ST_TREE;
      end
      MIX_GROWTH: begin
        if (n < 70) return ST_EMPTY;
        if (n < 75) return ST_BAD;
        if (n < 90) return ST_TREE;
        return ST_FIRE;
      end
      default: return STATE_W'($urandom_range(0, 3));
    endcase
  endfunction

  // draws lean toward zero, all ones and multiples of the period
  function automatic logic [DRAW_W-1:0] pick_draw();
    int p;
    int k;
    p = (period_reg == 0) ? 1 : int'(period_reg);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: begin
        k = $urandom_range(0, 65535 / p);
        return DRAW_W'(k * p);
      end
      default: return DRAW_W'($urandom);
    endcase
  endfunction

  // send one request on the cell input channel
  task automatic send_cell(input logic [STATE_W-1:0] st, input logic [DRAW_W-1:0] draw);
    int gap;
    gap = sender_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      cell_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_in_bus.valid       <= 1'b1;
    cell_in_bus.cell_state  <= st;
    cell_in_bus.growth_draw <= draw;
    @(posedge clk);
    while (!cell_in_bus.ready) @(posedge clk);
    absorb_cell(st, draw);
  endtask

  task automatic stream_cells(input int count, input cell_mix_t mix);
    for (int i = 0; i < count; i++)
      send_cell(pick_state(mix), pick_draw());
  endtask

  // stop sending and let the block go idle
  task automatic settle();
    cell_in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic idx, input logic wr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic idx, input logic [CFG_DATA_W-1:0] want);
    apb_transfer(idx, 1'b0, '0);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read", idx), want, prdata);
  endtask

  // write with junk above the field, then read back the field
  task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] mask;
    mask = (idx == REG_GROWTH_PERIOD) ? CFG_DATA_W'(16'hFFFF) : CFG_DATA_W'(1);
    apb_transfer(idx, 1'b1, (CFG_DATA_W'($urandom) & ~mask) | (value & mask));
    if (idx == REG_GROWTH_PERIOD)
      period_reg = DRAW_W'(value);
    else
      moore_reg = value[0];
    check_register(idx, value & mask);
  endtask

  // result checker
  initial begin
    cell_result_t want;
    cell_result_t got;
    int           stall;
    cell_out_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (receiver_hold > 0) begin
        cell_out_bus.ready <= 1'b0;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
      end
      stall = receiver_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall > 0) begin
        cell_out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cell_out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!cell_out_bus.valid) @(posedge clk);
      got.state = cell_out_bus.next_state;
      got.row   = cell_out_bus.out_row;
      got.col   = cell_out_bus.out_col;
      got.last  = cell_out_bus.frame_last;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, row", 0, 32'(got.row));
      end else begin
        want = pending_results.pop_front();
        if (got.state !== want.state)
          report_mismatch($sformatf("next_state at row %0d col %0d", want.row, want.col),
                          32'(want.state), 32'(got.state));
        if (got.row !== want.row)
          report_mismatch("out_row", 32'(want.row), 32'(got.row));
        if (got.col !== want.col)
          report_mismatch($sformatf("out_col in row %0d", want.row),
                          32'(want.col), 32'(got.col));
        if (got.last !== want.last)
          report_mismatch($sformatf("frame_last at row %0d col %0d", want.row, want.col),
                          32'(want.last), 32'(got.last));
      end
    end
  end

  // watchdog on cycles without any accepted request or taken result
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cell_in_bus.valid && cell_in_bus.ready) || (cell_out_bus.valid && cell_out_bus.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_register_defaults();
    check_register(REG_GROWTH_PERIOD, CFG_DATA_W'(GROWTH_PERIOD_RESET));
    check_register(REG_NEIGHBOURHOOD, CFG_DATA_W'(NEIGHBOURHOOD_RESET));
  endtask

  // fixed pattern at the left edge of the first two rows: top edge, left
  // edge, unused state code, growth draws at zero, all ones and period
  // multiples
  task automatic test_directed_cells();
    logic [STATE_W-1:0] pat_state [24] = '{
      ST_FIRE, ST_TREE, ST_TREE, ST_EMPTY, ST_EMPTY, ST_EMPTY, ST_BAD, ST_BAD,
      ST_TREE, ST_EMPTY, ST_TREE, ST_FIRE, ST_TREE, ST_TREE, ST_TREE, ST_FIRE,
      ST_EMPTY, ST_TREE, ST_TREE, ST_TREE, ST_BAD, ST_FIRE, ST_FIRE, ST_TREE};
    logic [DRAW_W-1:0] pat_draw [24] = '{
      16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd100, 16'd99, 16'd200, 16'hFFFF,
      16'hAAAA, 16'h5555, 16'd7, 16'd0, 16'd300, 16'hFFFF, 16'd0, 16'hFFFF,
      16'd65500, 16'h8000, 16'h0001, 16'd400, 16'd0, 16'h7FFF, 16'hFFFE, 16'h5555};
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    for (int i = 0; i < 24; i++)
      send_cell(pat_state[i], pat_draw[i]);
    stream_cells(GRID_COLUMNS - 24, MIX_FOREST);
    for (int i = 0; i < 24; i++)
      send_cell(pat_state[i], pat_draw[i]);
    settle();
  endtask

  task automatic test_von_neumann();
    write_register(REG_NEIGHBOURHOOD, CFG_DATA_W'(MODE_VON_NEUMANN));
    write_register(REG_GROWTH_PERIOD, 1);
    stream_cells(300, MIX_FOREST);
    settle();
  endtask

  task automatic test_period_extremes();
    write_register(REG_NEIGHBOURHOOD, CFG_DATA_W'(MODE_MOORE));
    // zero period acts as one: every empty cell grows
    write_register(REG_GROWTH_PERIOD, 0);
    stream_cells(100, MIX_GROWTH);
    settle();
    write_register(REG_GROWTH_PERIOD, CFG_DATA_W'(16'hFFFF));
    stream_cells(100, MIX_GROWTH);
    settle();
    write_register(REG_GROWTH_PERIOD, 2);
    stream_cells(100, MIX_GROWTH);
    settle();
  endtask

  // long hold on the output while input keeps coming
  task automatic test_output_backpressure();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    receiver_hold = HOLD_CYCLES;
    stream_cells(200, MIX_FOREST);
    settle();
  endtask

  // random chunks, gaps switched per chunk
  task automatic test_random_traffic();
    int sent;
    int chunk;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      chunk         = $urandom_range(20, 100);
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: write_register(REG_GROWTH_PERIOD, 0);
        1: write_register(REG_GROWTH_PERIOD, CFG_DATA_W'(16'hFFFF));
        default: write_register(REG_GROWTH_PERIOD, $urandom_range(1, 65535));
      endcase
      write_register(REG_NEIGHBOURHOOD, CFG_DATA_W'($urandom_range(0, 1)));
      stream_cells(chunk, cell_mix_t'($urandom_range(0, 2)));
      settle();
      sent += chunk;
    end
  endtask

  // main sequence
  initial begin
    fail_count    = 0;
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    receiver_hold = 0;
    reset_prediction();
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    cell_in_bus.valid       <= 1'b0;
    cell_in_bus.cell_state  <= ST_EMPTY;
    cell_in_bus.growth_draw <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_directed_cells();
    test_von_neumann();
    test_period_extremes();
    test_output_backpressure();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule : forest_fire_automaton_step_tb

`default_nettype wire
